FILE: rtl/core/sdd_pkg.sv
package sdd_pkg;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_SCAN   = 2'd1;
    localparam logic [1:0] MODE_SCROLL = 2'd2;

    localparam logic [7:0] CHAR_LEFT  = 8'h3C;
    localparam logic [7:0] CHAR_RIGHT = 8'h3E;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef enum logic [2:0] {
        OP_LEFT   = 3'd0,
        OP_RIGHT  = 3'd1,
        OP_EOL    = 3'd2,
        OP_DIGIT  = 3'd3,
        OP_SCAN   = 3'd4,
        OP_SCROLL = 3'd5
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic [3:0]  digit;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic overflow;
    } back_status_t;

    // Active-low seven-segment code of a decimal digit.
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/core/scrolling_digit_display.sv
// A scan beat is queued at the accepting edge and moved into the back end's output register
// when it is popped; the pop waits while the output register holds an untaken result.
// One beat per cycle for bytes and scans while the queue has room and the back end is free;
// a scroll beat with scrolling on holds the back end for the pop and the refill, one cell per cycle.
// Reset: synchronous, active low; clears control state and blanks all cells.
// The digit entry store is not cleared.
module scrolling_digit_display #(
    parameter int MAX_DIGITS = 10,
    parameter int CELLS      = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_rx_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_segments,
    output logic [7:0] m_digit_enable,
    output logic       m_overflow
);
    import sdd_pkg::*;

    logic         push;
    op_t          push_op;
    logic         pop;
    op_t          head_op;
    q_status_t    q_status;
    back_status_t back_status;

    sdd_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_rx_char (s_rx_char),
        .q_status  (q_status),
        .push      (push),
        .push_op   (push_op)
    );

    sdd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    sdd_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .CELLS      (CELLS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_op        (head_op),
        .q_status       (q_status),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segments     (m_segments),
        .m_digit_enable (m_digit_enable),
        .m_overflow     (m_overflow),
        .back_status    (back_status)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_no_pop_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.busy |-> !pop)
        else $error("queue popped during cell refill");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.overflow |=> back_status.overflow)
        else $error("overflow flag cleared without reset");

    a_enable_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_digit_enable))
        else $error("digit enable has more than one bit set");
`endif

endmodule

FILE: rtl/core/sdd_front.sv
module sdd_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [7:0]          s_rx_char,
    input  sdd_pkg::q_status_t  q_status,
    output logic                push,
    output sdd_pkg::op_t        push_op
);
    import sdd_pkg::*;

    logic keep;

    assign s_ready = !q_status.full;

    // Bytes other than the arrows, CR, LF and digits, and the spare mode, are dropped here and never queued.
    always_comb begin
        keep          = 1'b0;
        push_op.code  = OP_SCAN;
        push_op.digit = 4'd0;
        case (s_mode)
            MODE_BYTE: begin
                case (s_rx_char) inside
                    CHAR_LEFT: begin
                        keep         = 1'b1;
                        push_op.code = OP_LEFT;
                    end
                    CHAR_RIGHT: begin
                        keep         = 1'b1;
                        push_op.code = OP_RIGHT;
                    end
                    CHAR_CR, CHAR_LF: begin
                        keep         = 1'b1;
                        push_op.code = OP_EOL;
                    end
                    [CHAR_ZERO:CHAR_NINE]: begin
                        keep          = 1'b1;
                        push_op.code  = OP_DIGIT;
                        push_op.digit = s_rx_char[3:0];
                    end
                    default: keep = 1'b0;
                endcase
            end
            MODE_SCAN: begin
                keep         = 1'b1;
                push_op.code = OP_SCAN;
            end
            MODE_SCROLL: begin
                keep         = 1'b1;
                push_op.code = OP_SCROLL;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = s_valid && s_ready && keep;

endmodule

FILE: rtl/core/sdd_queue.sv
module sdd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sdd_pkg::op_t        push_op,
    input  logic                pop,
    output sdd_pkg::op_t        head_op,
    output sdd_pkg::q_status_t  q_status
);
    import sdd_pkg::*;

    op_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op        = mem_reg[rd_ptr_reg];
    assign q_status.empty = (cnt_reg == '0);
    assign q_status.full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));

endmodule

FILE: rtl/core/sdd_back.sv
module sdd_back #(
    parameter int MAX_DIGITS = 10,
    parameter int CELLS      = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sdd_pkg::op_t           head_op,
    input  sdd_pkg::q_status_t     q_status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_segments,
    output logic [7:0]             m_digit_enable,
    output logic                   m_overflow,
    output sdd_pkg::back_status_t  back_status
);
    import sdd_pkg::*;

    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int POS_W  = $clog2(MAX_DIGITS + 3);
    localparam int SCAN_W = $clog2(CELLS);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_FILL = 2'b10
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [3:0]        entry_reg [MAX_DIGITS];
    logic              entry_we;
    logic [IDX_W-1:0]  entry_wa;
    logic [3:0]        entry_wd;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  shown_reg, shown_next;
    logic [POS_W-1:0]  wstart_reg, wstart_next;
    logic              left_reg, left_next;
    logic              scroll_on_reg, scroll_on_next;
    logic [7:0]        cell_reg [CELLS];
    logic [7:0]        cell_next [CELLS];
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic              ovf_reg, ovf_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SCAN_W-1:0] fill_reg, fill_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_seg_reg, m_seg_next;
    logic [7:0]        m_en_reg, m_en_next;
    logic              m_ovf_reg, m_ovf_next;
    logic [POS_W-1:0]  text_len;
    logic [POS_W-1:0]  pos_inc;
    logic [7:0]        fill_pat;
    logic [7:0]        en_vec;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_RUN) && !q_status.empty
                      && ((head_op.code != OP_SCAN) || out_free);

    // The text is the latched digits followed by two blank cells.
    assign text_len = POS_W'(shown_reg) + POS_W'(2);
    assign pos_inc  = pos_reg + 1'b1;
    assign fill_pat = (pos_reg < POS_W'(shown_reg))
                      ? seg_code(entry_reg[pos_reg[IDX_W-1:0]]) : SEG_BLANK;

    // Cells beyond the eighth have no enable bit.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            en_vec[b] = (int'(scan_reg) == b);
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        shown_next     = shown_reg;
        wstart_next    = wstart_reg;
        left_next      = left_reg;
        scroll_on_next = scroll_on_reg;
        cell_next      = cell_reg;
        scan_next      = scan_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_seg_next     = m_seg_reg;
        m_en_next      = m_en_reg;
        m_ovf_next     = m_ovf_reg;
        entry_we       = 1'b0;
        entry_wa       = count_reg[IDX_W-1:0];
        entry_wd       = head_op.digit;
        case (state_reg)
            ST_RUN: begin
                if (pop) begin
                    case (head_op.code)
                        OP_LEFT:  left_next = 1'b1;
                        OP_RIGHT: left_next = 1'b0;
                        OP_EOL: begin
                            if (count_reg != '0) begin
                                shown_next     = count_reg;
                                wstart_next    = '0;
                                scroll_on_next = 1'b1;
                            end
                            count_next = '0;
                        end
                        OP_DIGIT: begin
                            if (count_reg < CNT_W'(MAX_DIGITS)) begin
                                entry_we   = 1'b1;
                                count_next = count_reg + 1'b1;
                                for (int j = 0; j < CELLS - 1; j++) begin
                                    cell_next[j] = cell_reg[j+1];
                                end
                                cell_next[CELLS-1] = seg_code(head_op.digit);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_SCAN: begin
                            m_valid_next = 1'b1;
                            m_seg_next   = cell_reg[scan_reg];
                            m_en_next    = en_vec;
                            m_ovf_next   = ovf_reg;
                            scan_next    = (scan_reg == SCAN_W'(CELLS - 1))
                                           ? '0 : scan_reg + 1'b1;
                        end
                        OP_SCROLL: begin
                            if (scroll_on_reg) begin
                                pos_next   = wstart_reg;
                                fill_next  = '0;
                                state_next = ST_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                // One cell per cycle, the window position walking with wrap.
                cell_next[fill_reg] = fill_pat;
                pos_next  = (pos_inc == text_len) ? '0 : pos_inc;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == SCAN_W'(CELLS - 1)) begin
                    state_next = ST_RUN;
                    if (left_reg) begin
                        wstart_next = (wstart_reg == '0) ? text_len - 1'b1
                                                          : wstart_reg - 1'b1;
                    end else begin
                        wstart_next = (wstart_reg + 1'b1 == text_len)
                                      ? '0 : wstart_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            shown_reg     <= '0;
            wstart_reg    <= '0;
            left_reg      <= 1'b0;
            scroll_on_reg <= 1'b0;
            scan_reg      <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
            for (int c = 0; c < CELLS; c++) begin
                cell_reg[c] <= SEG_BLANK;
            end
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            shown_reg     <= shown_next;
            wstart_reg    <= wstart_next;
            left_reg      <= left_next;
            scroll_on_reg <= scroll_on_next;
            scan_reg      <= scan_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
            cell_reg      <= cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_seg_reg <= m_seg_next;
        m_en_reg  <= m_en_next;
        m_ovf_reg <= m_ovf_next;
        if (entry_we) begin
            entry_reg[entry_wa] <= entry_wd;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_segments           = m_seg_reg;
    assign m_digit_enable       = m_en_reg;
    assign m_overflow           = m_ovf_reg;
    assign back_status.busy     = (state_reg == ST_FILL);
    assign back_status.overflow = ovf_reg;

endmodule

FILE: bench/marquee_scan_checker.sv
module marquee_scan_checker #(
    parameter int MAX_DIGITS = 10,
    parameter int CELLS      = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_rx_char,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_segments,
    input  logic [7:0] m_digit_enable,
    input  logic       m_overflow,
    output int         fail_count,
    output int         pending
);
    import sdd_pkg::*;

    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_enable;
        logic       overflow;
    } scan_beat_t;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // Display state as the block should hold it.
    logic [3:0] typed_digits [MAX_DIGITS];
    int         typed_count;
    int         text_digits;
    int         window_pos;
    logic       step_left;
    logic       scroll_running;
    logic [7:0] cell_glyph [CELLS];
    int         scan_cell;
    logic       overflow_seen;
    int         mismatches   = 0;
    int         queued_scans = 0;

    scan_beat_t expected_scans [$];

    assign fail_count = mismatches;
    assign pending    = queued_scans;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_display();
        typed_count    = 0;
        text_digits    = 0;
        window_pos     = 0;
        step_left      = 1'b0;
        scroll_running = 1'b0;
        scan_cell      = 0;
        overflow_seen  = 1'b0;
        for (int i = 0; i < CELLS; i++) cell_glyph[i] = SEG_BLANK;
        expected_scans.delete();
    endfunction

    function automatic void advance_marquee(input logic [1:0] mode, input logic [7:0] ch);
        int         text_len;
        int         idx;
        int         d;
        scan_beat_t beat;
        case (mode)
            MODE_BYTE: begin
                if (ch == CHAR_LEFT) begin
                    step_left = 1'b1;
                end else if (ch == CHAR_RIGHT) begin
                    step_left = 1'b0;
                end else if (ch == CHAR_CR || ch == CHAR_LF) begin
                    if (typed_count != 0) begin
                        text_digits    = typed_count;
                        window_pos     = 0;
                        scroll_running = 1'b1;
                    end
                    typed_count = 0;
                end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    d = int'(ch - CHAR_ZERO);
                    if (typed_count < MAX_DIGITS) begin
                        typed_digits[typed_count] = d[3:0];
                        typed_count++;
                        // The echo pushes everything one cell to the left.
                        for (int j = 0; j + 1 < CELLS; j++) cell_glyph[j] = cell_glyph[j + 1];
                        cell_glyph[CELLS - 1] = DIGIT_GLYPH[d];
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
            end
            MODE_SCROLL: begin
                if (scroll_running) begin
                    // The text is followed by two blank cells before it wraps.
                    text_len = text_digits + 2;
                    for (int i = 0; i < CELLS; i++) begin
                        idx = (window_pos + i) % text_len;
                        if (idx < text_digits)
                            cell_glyph[i] = DIGIT_GLYPH[typed_digits[idx]];
                        else
                            cell_glyph[i] = SEG_BLANK;
                    end
                    if (step_left)
                        window_pos = (window_pos + text_len - 1) % text_len;
                    else
                        window_pos = (window_pos + 1) % text_len;
                end
            end
            MODE_SCAN: begin
                beat.segments     = cell_glyph[scan_cell];
                beat.digit_enable = (scan_cell < 8) ? (8'h01 << scan_cell) : 8'h00;
                beat.overflow     = overflow_seen;
                expected_scans.push_back(beat);
                scan_cell = (scan_cell + 1) % CELLS;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_scan();
        scan_beat_t want;
        if (expected_scans.size() == 0) begin
            report_mismatch($sformatf("unexpected scan beat segments %h enable %h",
                                      m_segments, m_digit_enable));
        end else begin
            want = expected_scans.pop_front();
            if (m_segments !== want.segments)
                report_mismatch($sformatf("segments %h, predicted %h",
                                          m_segments, want.segments));
            if (m_digit_enable !== want.digit_enable)
                report_mismatch($sformatf("digit_enable %h, predicted %h",
                                          m_digit_enable, want.digit_enable));
            if (m_overflow !== want.overflow)
                report_mismatch($sformatf("overflow %b, predicted %b",
                                          m_overflow, want.overflow));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_display();
        end else begin
            if (m_valid && m_ready) check_scan();
            if (s_valid && s_ready) advance_marquee(s_mode, s_rx_char);
        end
        queued_scans = expected_scans.size();
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    import sdd_pkg::*;

    localparam int         MAX_DIGITS = 10;
    localparam int         CELLS      = 8;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         HOLD_LEN   = 300;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [7:0] s_rx_char;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_segments;
    logic [7:0] m_digit_enable;
    logic       m_overflow;

    int fail_count;
    int pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int useful_beats   = 0;

    always #6 aclk = ~aclk;

    scrolling_digit_display #(
        .MAX_DIGITS(MAX_DIGITS),
        .CELLS     (CELLS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_rx_char     (s_rx_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_segments    (m_segments),
        .m_digit_enable(m_digit_enable),
        .m_overflow    (m_overflow)
    );

    marquee_scan_checker #(
        .MAX_DIGITS(MAX_DIGITS),
        .CELLS     (CELLS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_rx_char     (s_rx_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_segments    (m_segments),
        .m_digit_enable(m_digit_enable),
        .m_overflow    (m_overflow),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one beat and returns at the falling edge after it was taken.
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_mode    = mode;
        s_rx_char = ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (mode == MODE_SCAN || mode == MODE_SCROLL)
            useful_beats++;
        else if (mode == MODE_BYTE && (ch == CHAR_LEFT || ch == CHAR_RIGHT || ch == CHAR_CR ||
                 ch == CHAR_LF || (ch >= CHAR_ZERO && ch <= CHAR_NINE)))
            useful_beats++;
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_beat(MODE_BYTE, ch);
    endtask

    task automatic send_ticks(input logic [1:0] mode, input int count);
        for (int i = 0; i < count; i++) send_beat(mode, 8'($urandom));
    endtask

    task automatic send_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3: begin
                // Mostly a proper entry; sometimes one of 10 to 14 digits, which overflows above 10.
                n = ($urandom_range(5) == 0) ? $urandom_range(14, 10) : $urandom_range(9, 1);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(15) == 0) send_byte(8'($urandom));
                    send_byte(CHAR_ZERO + 8'($urandom_range(9)));
                end
                if ($urandom_range(7) != 0) send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
            end
            4, 5: begin
                send_ticks(MODE_SCROLL, 1);
                send_ticks(MODE_SCAN, $urandom_range(9, 1));
            end
            6: send_ticks(MODE_SCAN, $urandom_range(10, 1));
            7: send_byte($urandom_range(1) ? CHAR_LEFT : CHAR_RIGHT);
            8: send_beat(2'($urandom_range(3)), 8'($urandom));
            default: begin
                if ($urandom_range(1))
                    send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
                else
                    send_beat(MODE_SPARE, 8'($urandom));
            end
        endcase
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_mode    = MODE_BYTE;
        s_rx_char = 8'h00;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: an idle scroll tick, a scan, ignored bytes, a full entry, overflow, both directions.
        send_ticks(MODE_SCROLL, 1);
        send_ticks(MODE_SCAN, 1);
        send_byte(CHAR_CR);
        send_beat(MODE_SPARE, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_ZERO - 8'd1);
        send_byte(CHAR_NINE + 8'd1);
        for (int d = 0; d < MAX_DIGITS; d++) send_byte(CHAR_ZERO + 8'(d));
        send_byte(CHAR_ZERO + 8'd5);
        send_ticks(MODE_SCAN, 2);
        send_byte(CHAR_LEFT);
        send_byte(CHAR_LF);
        send_ticks(MODE_SCROLL, 1);
        send_ticks(MODE_SCAN, 1);
        send_byte(CHAR_RIGHT);
        send_ticks(MODE_SCROLL, 1);
        send_ticks(MODE_SCAN, 1);

        useful_beats = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (phase == 0) begin
                // Keep scans coming while the result side holds off, so the block backs up.
                hold_requests++;
                send_ticks(MODE_SCAN, 24);
            end
            while (useful_beats < (phase + 1) * 125) send_random_sequence();
        end
        s_valid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (4 * CELLS) @(negedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: scrolling_digit_display.f
rtl/core/sdd_pkg.sv
rtl/core/sdd_front.sv
rtl/core/sdd_queue.sv
rtl/core/sdd_back.sv
rtl/core/scrolling_digit_display.sv
bench/marquee_scan_checker.sv
bench/testbench.sv
